@@ src/hfd_pkg.sv @@
package hfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam int          CNT_W       = 3;
    localparam int          RAW_W       = 20;
    localparam int          HUM_C_W     = 14;
    localparam int          TEMP_C_W    = 15;
    localparam int          OUT_DATA_W  = 88;

    // byte positions inside a frame
    localparam logic [CNT_W-1:0] IDX_STATUS = 3'd0;
    localparam logic [CNT_W-1:0] IDX_HUM_HI = 3'd1;
    localparam logic [CNT_W-1:0] IDX_HUM_MD = 3'd2;
    localparam logic [CNT_W-1:0] IDX_SPLIT  = 3'd3;
    localparam logic [CNT_W-1:0] IDX_TMP_MD = 3'd4;
    localparam logic [CNT_W-1:0] IDX_TMP_LO = 3'd5;
    localparam logic [CNT_W-1:0] IDX_CRC    = 3'd6;
    localparam logic [CNT_W-1:0] IDX_OVER   = 3'd7;

    localparam logic [HUM_C_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [HUM_C_W-1:0]  HUM_MAX     = 14'd10000;
    localparam logic [TEMP_C_W-1:0] TEMP_SCALE  = 15'd20000;
    localparam logic [TEMP_C_W-1:0] TEMP_OFFSET = 15'd5000;

    localparam int BIT_BUSY  = 7;
    localparam int BIT_CALIB = 3;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_BUSY    = 2'd1,
        RES_CRC_ERR = 2'd2,
        RES_BAD_LEN = 2'd3
    } hfd_result_t;

    typedef struct packed {
        hfd_result_t      code;
        logic [7:0]       status;
        logic [RAW_W-1:0] hum_raw;
        logic [RAW_W-1:0] temp_raw;
        logic [7:0]       crc;
    } hfd_frame_t;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/humidity_temp_frame_decoder_top.sv @@
// a result beat is offered once the last byte of its frame has passed the unpack record
//   register and the scaling output register; one byte beat per cycle while the output side
//   drains, set by the combinational crc and unpack step and the one multiply stage after it
// rst_n is asynchronous and active low: crc goes to 0xff, byte count and held
//   fields to zero, and both pipeline stages empty
module humidity_temp_frame_decoder_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // frame byte input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tuser,  // [0] first_byte
    input  logic                           s_axis_tlast,  // last_byte
    // decoded frame output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] result_code, [2] calibrated, [10:3] status_value,
    // [30:11] humidity_raw, [50:31] temperature_raw, [64:51] humidity_centi,
    // [79:65] temperature_centi, [87:80] crc_computed
    output logic [hfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import hfd_pkg::*;

    // frame record between the unpack stage and the scaling stage
    hfd_frame_t rec;
    logic       rec_valid;
    logic       rec_ready;

    // stage one: running crc, byte counting, field unpack; a record per last byte
    hfd_frame_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_first  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    // stage two: fixed-point scaling into hundredths and result packing
    hfd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ src/hfd_frame_unpack.sv @@
module hfd_frame_unpack (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_first,
    input  logic                in_last,
    output logic                rec_valid,
    input  logic                rec_ready,
    output hfd_pkg::hfd_frame_t rec
);
    import hfd_pkg::*;

    logic [7:0]       crc_reg,  crc_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [7:0]       stat_reg, stat_next;
    logic [RAW_W-1:0] hum_reg,  hum_next;
    logic [RAW_W-1:0] temp_reg, temp_next;
    logic             rec_valid_reg, rec_valid_next;
    hfd_frame_t       rec_reg, rec_next;

    logic [CNT_W-1:0] idx;
    logic [7:0]       crc_in;
    logic [7:0]       crc_upd;
    logic             accept;

    assign in_ready  = !rec_valid_reg || rec_ready;
    assign accept    = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    always_comb
    begin
        idx       = in_first ? IDX_STATUS : cnt_reg;
        crc_in    = in_first ? CRC_INIT : crc_reg;
        crc_upd   = (idx <= IDX_TMP_LO) ? crc8_byte(crc_in, in_byte) : crc_in;
        stat_next = stat_reg;
        hum_next  = hum_reg;
        temp_next = temp_reg;
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        rec_next  = rec_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;

        unique case (idx)
            IDX_STATUS: stat_next = in_byte;
            IDX_HUM_HI: hum_next  = {in_byte, hum_reg[11:0]};
            IDX_HUM_MD: hum_next  = {hum_reg[19:12], in_byte, hum_reg[3:0]};
            IDX_SPLIT:
            begin
                hum_next  = {hum_reg[19:4], in_byte[7:4]};
                temp_next = {in_byte[3:0], temp_reg[15:0]};
            end
            IDX_TMP_MD: temp_next = {temp_reg[19:16], in_byte, temp_reg[7:0]};
            IDX_TMP_LO: temp_next = {temp_reg[19:8], in_byte};
            default:    ;
        endcase

        if (accept)
        begin
            if (in_last)
            begin
                crc_next       = CRC_INIT;
                cnt_next       = IDX_STATUS;
                rec_valid_next = 1'b1;
                if (idx != IDX_TMP_LO && idx != IDX_CRC)
                begin
                    rec_next      = '0;
                    rec_next.code = RES_BAD_LEN;
                end
                else
                begin
                    if (stat_next[BIT_BUSY])
                        rec_next.code = RES_BUSY;
                    else if (idx == IDX_CRC && crc_upd != in_byte)
                        rec_next.code = RES_CRC_ERR;
                    else
                        rec_next.code = RES_OK;
                    rec_next.status   = stat_next;
                    rec_next.hum_raw  = hum_next;
                    rec_next.temp_raw = temp_next;
                    rec_next.crc      = crc_upd;
                end
            end
            else
            begin
                crc_next = crc_upd;
                cnt_next = (idx == IDX_OVER) ? IDX_OVER : idx + 3'd1;
            end
        end
        else
        begin
            stat_next = stat_reg;
            hum_next  = hum_reg;
            temp_next = temp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            cnt_reg       <= IDX_STATUS;
            stat_reg      <= '0;
            hum_reg       <= '0;
            temp_reg      <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
            stat_reg      <= stat_next;
            hum_reg       <= hum_next;
            temp_reg      <= temp_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

@@ src/hfd_scale.sv @@
module hfd_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rec_valid,
    output logic                           rec_ready,
    input  hfd_pkg::hfd_frame_t            rec,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hfd_pkg::OUT_DATA_W-1:0] out_data
);
    import hfd_pkg::*;

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]     data_reg, data_next;
    logic [RAW_W+HUM_C_W-1:0]  hum_prod;
    logic [RAW_W+TEMP_C_W-1:0] temp_prod;
    logic [HUM_C_W-1:0]        hum_c;
    logic [TEMP_C_W-1:0]       temp_c;
    logic                      load;

    assign rec_ready = !out_valid_reg || out_ready;
    assign load      = rec_valid && rec_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        hum_prod  = (RAW_W+HUM_C_W)'(rec.hum_raw) * (RAW_W+HUM_C_W)'(HUM_SCALE);
        temp_prod = (RAW_W+TEMP_C_W)'(rec.temp_raw) * (RAW_W+TEMP_C_W)'(TEMP_SCALE);
        hum_c     = hum_prod[RAW_W+HUM_C_W-1:RAW_W];
        if (hum_c > HUM_MAX)
            hum_c = HUM_MAX;
        temp_c    = temp_prod[RAW_W+TEMP_C_W-1:RAW_W] - TEMP_OFFSET;
        // bad length frames report zero everywhere but the code
        if (rec.code == RES_BAD_LEN)
        begin
            hum_c  = '0;
            temp_c = '0;
        end
        data_next = {rec.crc, temp_c, hum_c, rec.temp_raw, rec.hum_raw, rec.status,
                     rec.status[BIT_CALIB], rec.code};
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

@@ src/hfd_checker.sv @@
module hfd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import hfd_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // bad length frames carry nothing but the code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == RES_BAD_LEN |-> m_axis_tdata[87:2] == '0)
        else $error("bad length result with nonzero fields");

    // humidity stays clamped
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[64:51] <= HUM_MAX)
        else $error("humidity out of range");

    // busy code only with the busy status bit set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == RES_BUSY |-> m_axis_tdata[3+BIT_BUSY])
        else $error("busy code without busy status");

    // a ready receiver never holds off byte beats
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("byte input blocked with receiver ready");

endmodule

bind humidity_temp_frame_decoder_top hfd_checker u_hfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/humidity_temp_frame_decoder_top_tb.sv @@
module humidity_temp_frame_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hfd_pkg::*;

    // generous cycle budget: ~2000 byte beats, heavy idling and stalls in later phases
    localparam int CYCLE_LIMIT = 400000;
    // beats of random stimulus per idling phase
    localparam int PHASE_BEATS = 500;

    typedef logic [7:0] byte_q_t[$];

    // m_axis_tdata layout, msb field first so the cast lines up with the port
    typedef struct packed {
        logic [7:0]         crc;
        logic signed [14:0] temp_c;
        logic [13:0]        hum_c;
        logic [19:0]        temp_raw;
        logic [19:0]        hum_raw;
        logic [7:0]         status;
        logic               calib;
        hfd_result_t        code;
    } decoded_t;

    class frame_scoreboard;
        logic [7:0]  crc_run;
        logic [2:0]  byte_idx;
        logic [7:0]  status_byte;
        logic [19:0] hum_bits;
        logic [19:0] temp_bits;
        decoded_t    decoded_q[$];
        int          errors;

        function new();
            crc_run     = CRC_INIT;
            byte_idx    = IDX_STATUS;
            status_byte = '0;
            hum_bits    = '0;
            temp_bits   = '0;
            errors      = 0;
        endfunction

        // crc-8 0x31, msb first, bit-serial over the incoming byte
        static function logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function int pending_count();
            return decoded_q.size();
        endfunction

        // one accepted byte beat: update frame state, queue a result on the last byte
        function void note_input(logic [7:0] d, logic first, logic last);
            logic [2:0]  idx;
            logic [7:0]  c;
            logic [34:0] hp;
            logic [34:0] tp;
            decoded_t    e;
            idx = first ? IDX_STATUS : byte_idx;
            c   = first ? CRC_INIT : crc_run;
            if (idx <= IDX_TMP_LO)
            begin
                c = crc8_step(c, d);
            end
            case (idx)
                IDX_STATUS: status_byte = d;
                IDX_HUM_HI: hum_bits[19:12] = d;
                IDX_HUM_MD: hum_bits[11:4] = d;
                IDX_SPLIT:
                begin
                    hum_bits[3:0]    = d[7:4];
                    temp_bits[19:16] = d[3:0];
                end
                IDX_TMP_MD: temp_bits[15:8] = d;
                IDX_TMP_LO: temp_bits[7:0] = d;
                default: ;
            endcase
            if (!last)
            begin
                crc_run  = c;
                byte_idx = (idx == IDX_OVER) ? IDX_OVER : idx + 3'd1;
                return;
            end
            crc_run  = CRC_INIT;
            byte_idx = IDX_STATUS;
            e = '0;
            if (idx != IDX_TMP_LO && idx != IDX_CRC)
            begin
                e.code = RES_BAD_LEN;
            end
            else
            begin
                if (status_byte[BIT_BUSY])
                    e.code = RES_BUSY;
                else if (idx == IDX_CRC && c != d)
                    e.code = RES_CRC_ERR;
                else
                    e.code = RES_OK;
                // hundredths, truncated by the shift
                hp = 35'(hum_bits) * 35'd10000;
                hp = hp >> 20;
                if (hp > 35'd10000)
                    hp = 35'd10000;
                tp = 35'(temp_bits) * 35'd20000;
                tp = tp >> 20;
                e.calib    = status_byte[BIT_CALIB];
                e.status   = status_byte;
                e.hum_raw  = hum_bits;
                e.temp_raw = temp_bits;
                e.hum_c    = hp[13:0];
                e.temp_c   = tp[14:0] - 15'd5000;
                e.crc      = c;
            end
            decoded_q.push_back(e);
        endfunction

        function void compare_field(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        // one accepted result beat against the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] tdata);
            decoded_t got;
            decoded_t e;
            got = decoded_t'(tdata);
            if (decoded_q.size() == 0)
            begin
                $error("result beat with no frame pending, tdata %h", tdata);
                errors++;
                return;
            end
            e = decoded_q.pop_front();
            compare_field("result_code", int'(e.code), int'(got.code));
            compare_field("calibrated", e.calib, got.calib);
            compare_field("status_value", e.status, got.status);
            compare_field("humidity_raw", e.hum_raw, got.hum_raw);
            compare_field("temperature_raw", e.temp_raw, got.temp_raw);
            compare_field("humidity_centi", e.hum_c, got.hum_c);
            compare_field("temperature_centi", $signed(e.temp_c), $signed(got.temp_c));
            compare_field("crc_computed", e.crc, got.crc);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    frame_scoreboard sb = new();

    // idling knobs, changed per phase
    int idle_pct = 0;
    int stall_pct = 0;
    int beats_sent = 0;
    int cycle_count = 0;

    humidity_temp_frame_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // receiver side: random stall at the phase's rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // byte beats taken by the block feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            sb.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        end
    end

    // result beats taken from the block are checked in order
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("humidity_temp_frame_decoder_top_tb: errors");
            $finish;
        end
    end

    // offer one byte beat, with random idle cycles ahead of it, and wait for the handshake
    task automatic send_beat(input logic [7:0] d, input logic f, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= f;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // whole frame: first mark optional, last mark on the final byte
    task automatic send_frame(input byte_q_t fb, input bit mark_first);
        foreach (fb[i])
        begin
            send_beat(fb[i], mark_first && (i == 0), i == fb.size() - 1);
        end
    endtask

    // status, packed raw values and crc; cut or padded to len bytes
    function automatic byte_q_t make_frame(logic [7:0] st, logic [19:0] h, logic [19:0] t,
                                           int len, bit bad_crc);
        byte_q_t    q;
        logic [7:0] c;
        q = {st, h[19:12], h[11:4], {h[3:0], t[19:16]}, t[15:8], t[7:0]};
        c = CRC_INIT;
        foreach (q[i])
        begin
            c = frame_scoreboard::crc8_step(c, q[i]);
        end
        if (bad_crc)
        begin
            c = c ^ 8'($urandom_range(255, 1));
        end
        q.push_back(c);
        while (q.size() < len)
        begin
            q.push_back(8'($urandom));
        end
        while (q.size() > len)
        begin
            void'(q.pop_back());
        end
        return q;
    endfunction

    // raw 20-bit value, biased toward the ends of the range
    function automatic logic [19:0] pick_raw();
        case ($urandom_range(9))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            default: return 20'($urandom);
        endcase
    endfunction

    initial
    begin
        byte_q_t     fq;
        int          kind;
        int          base;
        logic [7:0]  st;
        logic [19:0] h;
        logic [19:0] t;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames, no idling
        // good crc, calibrated, raw minimum: coldest temperature
        send_frame(make_frame(8'h08, 20'h00000, 20'h00000, 7, 1'b0), 1'b1);
        // six bytes, no crc check, busy, raw maximum; no first mark after a last byte
        send_frame(make_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 6, 1'b0), 1'b0);
        // crc mismatch, mid-scale humidity, quarter-scale temperature
        send_frame(make_frame(8'h00, 20'h80000, 20'h40000, 7, 1'b1), 1'b1);
        // single byte frame: bad length
        send_frame(make_frame(8'h77, 20'h12345, 20'h6789A, 1, 1'b0), 1'b1);
        // overlong frame with busy status: bad length wins over busy
        send_frame(make_frame(8'h80, 20'hABCDE, 20'h13579, 8, 1'b1), 1'b1);

        base = beats_sent;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    idle_pct  = 38;
                    stall_pct = 38;
                end
            endcase
            while (beats_sent < base + (ph + 1) * PHASE_BEATS)
            begin
                kind = $urandom_range(99);
                st = 8'($urandom);
                if ($urandom_range(99) < 75)
                begin
                    st[BIT_BUSY] = 1'b0;
                end
                h = pick_raw();
                t = pick_raw();
                if (kind < 60)
                begin
                    // well formed frame with crc
                    fq = make_frame(st, h, t, 7, 1'b0);
                    send_frame(fq, $urandom_range(99) < 80);
                end
                else if (kind < 70)
                begin
                    fq = make_frame(st, h, t, 7, 1'b1);
                    send_frame(fq, 1'b1);
                end
                else if (kind < 82)
                begin
                    fq = make_frame(st, h, t, 6, 1'b0);
                    send_frame(fq, $urandom_range(1));
                end
                else if (kind < 92)
                begin
                    // any length, short and overlong included
                    fq = make_frame(st, h, t, $urandom_range(10, 1), $urandom_range(1));
                    send_frame(fq, $urandom_range(1));
                end
                else
                begin
                    // noise: stray first marks restart a frame mid-way, stray last marks end it
                    repeat ($urandom_range(5, 1))
                    begin
                        send_beat(8'($urandom), $urandom_range(99) < 30,
                                  $urandom_range(99) < 20);
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
        begin
            @(posedge clk);
        end
        // idle margin after the last expected result, for stray result beats
        repeat (16) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("humidity_temp_frame_decoder_top_tb: clean");
        end
        else
        begin
            $display("humidity_temp_frame_decoder_top_tb: errors");
        end
        $finish;
    end

endmodule
